@@ src/rabin_karp_fingerprint_unit_macros.svh @@
// Assertion macros for the fingerprint unit checker.
`ifndef RABIN_KARP_FINGERPRINT_UNIT_MACROS_SVH
`define RABIN_KARP_FINGERPRINT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define RKF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define RKF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/rkf_pkg.sv @@
// Package: item types, command/status structs and register map of the fingerprint unit.
`default_nettype none

package rkf_pkg;

	// Input item
	typedef struct packed {
		logic [7:0] byte_value;
		logic       start_new;
		logic       last_byte;
	} item_t;

	// Result item
	typedef struct packed {
		logic [31:0] fingerprint_value;
		logic [31:0] power_value;
		logic [31:0] inverse_power_value;
		logic [31:0] sequence_length;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic item_load;   // latch item and load units for an update
		logic prep_load;   // load units to reduce base and base inverse
		logic prep;        // units run in reduction mode
		logic step;        // advance all units by one multiplier bit
		logic prep_store;  // capture reduced base and base inverse
		logic commit;      // write back state, load result if last
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;
	} status_t;

	// Register map
	localparam int PADDR_W = 4;
	localparam int CFG_W   = 32;
	localparam int COUNT_W = 32;

	localparam logic [1:0] REG_MODULUS      = 2'd0;
	localparam logic [1:0] REG_BASE         = 2'd1;
	localparam logic [1:0] REG_BASE_INVERSE = 2'd2;

	localparam logic [CFG_W-1:0] MODULUS_RST      = 32'd2147483647;
	localparam logic [CFG_W-1:0] BASE_RST         = 32'd256;
	localparam logic [CFG_W-1:0] BASE_INVERSE_RST = 32'd8388608;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

`default_nettype wire

@@ src/rabin_karp_fingerprint_unit.sv @@
// Top level of the Karp-Rabin fingerprint unit.
// Usage:
//   item channel   : one byte per item with start_new and last_byte flags.
//   result channel : fingerprint, r^n, r^-n and length, one per last_byte item.
//   config port    : APB-style; modulus at 0x0, base at 0x4, base_inverse at 0x8.
// Items: one item at a time; the next item is taken only after the current one is done,
//   paced by the four bit-serial modular multipliers that take one bit per cycle.
// Result: result_valid rises when the update of a last_byte item commits.
// Reset: state returns to fingerprint 0, powers 1, length 0; registers to their
//   defaults. After reset and after every register write the block reduces
//   base and base_inverse modulo the modulus, which holds item_ready low until
//   the reduction pass is over.
// Stall: the result register holds one result while the next item is taken and
//   worked on; a second last_byte item waits in its final cycle until the
//   pending result is taken.
// Widths above 32 behave as 32, since registers and state are 32 bits.
`default_nettype none

module rabin_karp_fingerprint_unit #(
	parameter int FIELD_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire rkf_pkg::item_t              item,
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output rkf_pkg::result_t                 result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [rkf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rkf_pkg::CFG_W-1:0]   pwdata,
	output logic      [rkf_pkg::CFG_W-1:0]   prdata,
	output logic                             pready
);
	import rkf_pkg::*;

	localparam int DW = (FIELD_WIDTH < 32) ? FIELD_WIDTH : 32;

	cmd_t             cmd;
	status_t          status;
	logic             cfg_wr;
	logic [CFG_W-1:0] modulus;
	logic [CFG_W-1:0] base;
	logic [CFG_W-1:0] base_inverse;

	assign pready = 1'b1;

	// Configuration registers
	rkf_regs u_regs (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.cfg_wr(cfg_wr), .modulus(modulus), .base(base), .base_inverse(base_inverse)
	);

	// Sequencer
	rkf_ctrl #(.DW(DW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.result_valid(result_valid), .result_ready(result_ready),
		.cfg_wr(cfg_wr), .status(status), .cmd(cmd)
	);

	// Arithmetic and state
	rkf_dp #(.DW(DW)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .status(status), .item(item),
		.modulus(modulus), .base(base), .base_inverse(base_inverse),
		.result(result)
	);

endmodule

`default_nettype wire

@@ src/rkf_regs.sv @@
// Configuration register file with APB-style access.
`default_nettype none

module rkf_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rkf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [rkf_pkg::CFG_W-1:0]   pwdata,
	output logic      [rkf_pkg::CFG_W-1:0]   prdata,
	output logic                            cfg_wr,
	output logic      [rkf_pkg::CFG_W-1:0]   modulus,
	output logic      [rkf_pkg::CFG_W-1:0]   base,
	output logic      [rkf_pkg::CFG_W-1:0]   base_inverse
);
	import rkf_pkg::*;

	logic [1:0]       idx;
	logic [CFG_W-1:0] modulus_q;
	logic [CFG_W-1:0] base_q;
	logic [CFG_W-1:0] base_inverse_q;

	assign idx    = paddr[3:2];
	assign cfg_wr = psel & penable & pwrite;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q      <= MODULUS_RST;
			base_q         <= BASE_RST;
			base_inverse_q <= BASE_INVERSE_RST;
		end else if (cfg_wr) begin
			unique case (idx)
				REG_MODULUS:      modulus_q      <= pwdata;
				REG_BASE:         base_q         <= pwdata;
				REG_BASE_INVERSE: base_inverse_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_MODULUS:      prdata = modulus_q;
			REG_BASE:         prdata = base_q;
			REG_BASE_INVERSE: prdata = base_inverse_q;
			default:          prdata = '0;
		endcase
	end

	assign modulus      = modulus_q;
	assign base         = base_q;
	assign base_inverse = base_inverse_q;

endmodule

`default_nettype wire

@@ src/rkf_mulmod.sv @@
// Bit-serial modular multiplier: one multiplier bit per cycle while step is high, MSB first.
`default_nettype none

module rkf_mulmod #(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         load,
	input  wire logic         step,
	input  wire logic [W-1:0] mult,
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] m,
	output logic      [W-1:0] acc
);
	logic [W-1:0] acc_q;
	logic [W-1:0] mult_q;
	logic [W+1:0] sum;
	logic [W+1:0] m1;
	logic [W+1:0] m2;
	logic [W-1:0] acc_nxt;

	// Double and add; the sum stays below three times the modulus
	always_comb begin
		m1  = {2'b00, m};
		m2  = {1'b0, m, 1'b0};
		sum = {1'b0, acc_q, 1'b0} + (mult_q[W-1] ? {2'b00, a} : '0);
		if (sum >= m2) begin
			acc_nxt = W'(sum - m2);
		end else if (sum >= m1) begin
			acc_nxt = W'(sum - m1);
		end else begin
			acc_nxt = W'(sum);
		end
	end

	// Clear on load, advance one bit per step
	always_ff @(posedge clk) begin
		if (load) begin
			acc_q  <= '0;
			mult_q <= mult;
		end else if (step) begin
			acc_q  <= acc_nxt;
			mult_q <= mult_q << 1;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

@@ src/rkf_dp.sv @@
// Datapath: running state, four modular multipliers and the result register.
`default_nettype none

module rkf_dp #(
	parameter int DW = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire rkf_pkg::cmd_t            cmd,
	output rkf_pkg::status_t              status,
	input  wire rkf_pkg::item_t           item,
	input  wire logic [rkf_pkg::CFG_W-1:0] modulus,
	input  wire logic [rkf_pkg::CFG_W-1:0] base,
	input  wire logic [rkf_pkg::CFG_W-1:0] base_inverse,
	output rkf_pkg::result_t              result
);
	import rkf_pkg::*;

	logic [DW-1:0]      m;
	logic               m_small;
	logic [DW-1:0]      one;

	logic [DW-1:0]      fp_q;
	logic [DW-1:0]      pw_q;
	logic [DW-1:0]      ipw_q;
	logic [COUNT_W-1:0] count_q;

	logic [DW-1:0]      r_red_q;
	logic [DW-1:0]      ri_red_q;
	logic [DW-1:0]      b_red_q;
	logic               start_q;
	logic               last_q;

	logic [DW-1:0]      mult0, mult1, mult2, mult3;
	logic [DW-1:0]      a2, a3;
	logic               load;
	logic [DW-1:0]      acc0, acc1, acc2, acc3;

	logic [DW:0]        fp_sum;
	logic [DW-1:0]      fp_nxt;
	logic [DW-1:0]      pw_nxt;
	logic [DW-1:0]      ipw_nxt;
	logic [COUNT_W-1:0] count_nxt;
	result_t            result_q;

	// Byte modulo m; only small moduli need the eight-step reduction
	function automatic logic [DW-1:0] byte_mod(input logic [7:0] b, input logic [DW-1:0] md);
		logic [8:0] rem;
		logic [8:0] m9;
		rem = '0;
		m9  = 9'(md);
		if (md > DW'(255)) begin
			return DW'(b);
		end
		for (int i = 7; i >= 0; i--) begin
			rem = {rem[7:0], b[i]};
			if (rem >= m9) begin
				rem = rem - m9;
			end
		end
		return DW'(rem);
	endfunction

	assign m       = modulus[DW-1:0];
	assign m_small = (m < DW'(2));
	assign one     = DW'(1);

	// Select unit operands: reduction of base terms, or the item update
	always_comb begin
		load  = cmd.item_load | cmd.prep_load;
		mult0 = item.start_new ? '0 : fp_q;
		mult1 = item.start_new ? one : pw_q;
		mult2 = cmd.prep_load ? base[DW-1:0] : mult1;
		mult3 = cmd.prep_load ? base_inverse[DW-1:0] : (item.start_new ? one : ipw_q);
		a2    = cmd.prep ? one : r_red_q;
		a3    = cmd.prep ? one : ri_red_q;
	end

	// Unit 0 reduces the stored fingerprint
	rkf_mulmod #(.W(DW)) u_fp (
		.clk(clk), .load(load), .step(cmd.step),
		.mult(mult0), .a(one), .m(m), .acc(acc0)
	);

	// Unit 1 forms byte times power
	rkf_mulmod #(.W(DW)) u_term (
		.clk(clk), .load(load), .step(cmd.step),
		.mult(mult1), .a(b_red_q), .m(m), .acc(acc1)
	);

	// Unit 2 advances the power, or reduces the base
	rkf_mulmod #(.W(DW)) u_pw (
		.clk(clk), .load(load), .step(cmd.step),
		.mult(mult2), .a(a2), .m(m), .acc(acc2)
	);

	// Unit 3 advances the inverse power, or reduces the base inverse
	rkf_mulmod #(.W(DW)) u_ipw (
		.clk(clk), .load(load), .step(cmd.step),
		.mult(mult3), .a(a3), .m(m), .acc(acc3)
	);

	// Latch item fields and reduced base terms
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			b_red_q <= byte_mod(item.byte_value, m);
			start_q <= item.start_new;
			last_q  <= item.last_byte;
		end
		if (cmd.prep_store) begin
			r_red_q  <= acc2;
			ri_red_q <= acc3;
		end
	end

	// Next state at the end of an update
	always_comb begin
		fp_sum = {1'b0, acc0} + {1'b0, acc1};
		if (fp_sum >= {1'b0, m}) begin
			fp_sum = fp_sum - {1'b0, m};
		end
		fp_nxt  = m_small ? '0 : fp_sum[DW-1:0];
		pw_nxt  = m_small ? '0 : acc2;
		ipw_nxt = m_small ? '0 : acc3;
		if (start_q) begin
			count_nxt = COUNT_W'(1);
		end else if (count_q == COUNT_MAX) begin
			count_nxt = count_q;
		end else begin
			count_nxt = count_q + COUNT_W'(1);
		end
	end

	// Running state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			pw_q    <= DW'(1);
			ipw_q   <= DW'(1);
			count_q <= '0;
		end else if (cmd.commit) begin
			fp_q    <= fp_nxt;
			pw_q    <= pw_nxt;
			ipw_q   <= ipw_nxt;
			count_q <= count_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit && last_q) begin
			result_q.fingerprint_value   <= 32'(fp_nxt);
			result_q.power_value         <= 32'(pw_nxt);
			result_q.inverse_power_value <= 32'(ipw_nxt);
			result_q.sequence_length     <= count_nxt;
		end
	end

	assign result      = result_q;
	assign status.last = last_q;

endmodule

`default_nettype wire

@@ src/rkf_ctrl.sv @@
// Controller: sequences base reduction passes and item updates, owns the handshakes.
`default_nettype none

module rkf_ctrl #(
	parameter int DW = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	output logic                  result_valid,
	input  wire logic             result_ready,
	input  wire logic             cfg_wr,
	input  wire rkf_pkg::status_t status,
	output rkf_pkg::cmd_t         cmd
);
	import rkf_pkg::*;

	localparam int CW = $clog2(DW);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_PREP     = 5'b00010,
		S_PREP_END = 5'b00100,
		S_RUN      = 5'b01000,
		S_DONE     = 5'b10000
	} state_t;

	state_t        state_q, state_nxt;
	logic [CW-1:0] cnt_q;
	logic          cnt_last;
	logic          dirty_q;
	logic          out_valid_q;
	logic          hold_done;

	assign cnt_last  = (cnt_q == CW'(DW - 1));
	assign hold_done = status.last & out_valid_q & ~result_ready;

	// Next state and commands
	always_comb begin
		state_nxt      = state_q;
		item_ready     = 1'b0;
		cmd            = '0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = ~dirty_q;
				if (dirty_q) begin
					cmd.prep_load = 1'b1;
					state_nxt     = S_PREP;
				end else if (item_valid) begin
					cmd.item_load = 1'b1;
					state_nxt     = S_RUN;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				cmd.step = 1'b1;
				if (cnt_last) begin
					state_nxt = S_PREP_END;
				end
			end
			S_PREP_END: begin
				cmd.prep_store = 1'b1;
				state_nxt      = S_IDLE;
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (cnt_last) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (!hold_done) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// State, bit counter, stale-base flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			dirty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.step) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cfg_wr) begin
				dirty_q <= 1'b1;
			end else if (cmd.prep_load) begin
				dirty_q <= 1'b0;
			end
			if (cmd.commit && status.last) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/rkf_checker.sv @@
// Port-level checker for the fingerprint unit, bound to the top level.
`default_nettype none
`include "rabin_karp_fingerprint_unit_macros.svh"

module rkf_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        item_valid,
	input wire logic                        item_ready,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire rkf_pkg::result_t            result,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic                        pready
);
	import rkf_pkg::*;

	logic item_acc;
	logic cfg_acc;

	assign item_acc = item_valid & item_ready;
	assign cfg_acc  = psel & penable & pwrite & pready;

	// One item at a time: no new item right after one is taken
	`RKF_ASSERT_NEXT(a_one_item, item_acc, !item_ready, "item_ready high after an accepted item")

	// A register write forces a base reduction pass before the next item
	`RKF_ASSERT_NEXT(a_cfg_blocks, cfg_acc, !item_ready, "item_ready high right after a register write")

	// A result never appears in the cycle after an item is taken
	`RKF_ASSERT_NEXT(a_no_early_result, item_acc, !$rose(result_valid), "result appeared too early")

	// A stalled result holds its value
	`RKF_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(result), "stalled result changed or dropped")

	// The config port never inserts wait states
	`RKF_ASSERT_NOW(a_pready, psel, pready, "pready low during an access")

endmodule

bind rabin_karp_fingerprint_unit rkf_checker u_rkf_checker (.*);

`default_nettype wire
